[hw/rtl/ifp_pkg.sv]
// Package for the serial frame parser: header codes, size limits,
// parser phase and result status types. No dependencies.
package ifp_pkg;

  localparam int unsigned MAX_PAYLOAD = 32;

  localparam logic [7:0] HEAD_FIRST  = 8'h55;
  localparam logic [7:0] HEAD_UPLOAD = 8'h55;
  localparam logic [7:0] HEAD_ACK    = 8'hAF;

  typedef enum logic [2:0] {
    PH_HEAD_L,
    PH_HEAD_H,
    PH_ID,
    PH_LEN,
    PH_DATA,
    PH_SUM,
    PH_PLAY
  } phase_e;

  typedef enum logic [1:0] {
    ST_PENDING,
    ST_GOOD,
    ST_ERROR
  } status_e;

endpackage

[hw/rtl/imu_serial_frame_parser.sv]
// Serial frame parser: header, id, length, payload and 8-bit sum check,
// with a payload memory replayed after a good check byte.
// Depends on ifp_pkg.
//
// Usage:
//   Input channel: one received byte per word on rx_byte_i, in_valid_i/in_ready_o.
//   Output channel: one result per word, out_valid_o/out_ready_i, fields on
//   status_o, frame_kind_o, frame_id_o, payload_len_o, byte_index_o,
//   payload_byte_o and last_o.
//   Every accepted byte gives exactly one result, except the check byte of a
//   good frame with a nonzero length, which gives one result per payload byte.
//   Results are registered: a result appears in the cycle after its byte is
//   accepted; the first payload word of a good frame passes through the memory
//   read register and then the output register after its check byte.
//   Throughput: one byte per cycle while parsing and the output is not stalled.
//   The replay of a good frame reads the payload memory once per cycle while
//   the receiver takes each word, and input is held off until the replay ends.
//   When the receiver stalls, the output register holds its word and the
//   input side stops accepting until that word is taken.
//   Reset: parser hunts for the first header byte, the output register is
//   empty. The payload memory is not cleared; it is only read after a write.
module imu_serial_frame_parser #(
  parameter int unsigned MaxPayload = ifp_pkg::MAX_PAYLOAD
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] rx_byte_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [1:0] status_o,
  output logic       frame_kind_o,
  output logic [7:0] frame_id_o,
  output logic [5:0] payload_len_o,
  output logic [4:0] byte_index_o,
  output logic [7:0] payload_byte_o,
  output logic       last_o
);
  import ifp_pkg::*;

  localparam int unsigned AW = (MaxPayload > 1) ? $clog2(MaxPayload) : 1;
  localparam int unsigned LW = $clog2(MaxPayload + 1);
  localparam int unsigned CW = LW + 1;

  phase_e          phase_q, phase_d;
  logic            kind_q, kind_d;
  logic [7:0]      id_q, id_d;
  logic [LW-1:0]   len_q, len_d;
  logic [AW-1:0]   cnt_q, cnt_d;
  logic [7:0]      sum_q, sum_d;
  logic [AW-1:0]   idx_q, idx_d;

  logic            out_valid_q;
  status_e         status_q, status_d;
  logic            kind_out_q, kind_out_d;
  logic [7:0]      id_out_q, id_out_d;
  logic [5:0]      len_out_q, len_out_d;
  logic [4:0]      idx_out_q, idx_out_d;
  logic [7:0]      byte_out_q, byte_out_d;
  logic            last_out_q, last_out_d;
  logic            load_out;

  logic [7:0]      mem_q [MaxPayload];
  logic [7:0]      rdata_q;
  logic            mem_we, mem_re;
  logic [AW-1:0]   mem_wa, mem_ra;

  logic            out_free, in_fire, play_last, data_last;
  logic [7:0]      sum_add;

  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = out_free && (phase_q != PH_PLAY);
  assign in_fire    = in_valid_i && in_ready_o;
  assign sum_add    = sum_q + rx_byte_i;
  assign play_last  = (CW'(idx_q) + CW'(1)) == CW'(len_q);
  assign data_last  = (CW'(cnt_q) + CW'(1)) >= CW'(len_q);

  // next state
  always_comb begin
    phase_d = phase_q;
    kind_d  = kind_q;
    id_d    = id_q;
    len_d   = len_q;
    cnt_d   = cnt_q;
    sum_d   = sum_q;
    idx_d   = idx_q;
    unique case (phase_q)
      PH_HEAD_L: begin
        if (in_fire && rx_byte_i == HEAD_FIRST) begin
          sum_d   = rx_byte_i;
          phase_d = PH_HEAD_H;
        end
      end
      PH_HEAD_H: begin
        if (in_fire) begin
          if (rx_byte_i == HEAD_UPLOAD || rx_byte_i == HEAD_ACK) begin
            kind_d  = (rx_byte_i == HEAD_ACK);
            sum_d   = sum_add;
            phase_d = PH_ID;
          end else begin
            phase_d = PH_HEAD_L;
          end
        end
      end
      PH_ID: begin
        if (in_fire) begin
          id_d    = rx_byte_i;
          sum_d   = sum_add;
          phase_d = PH_LEN;
        end
      end
      PH_LEN: begin
        if (in_fire) begin
          if ({1'b0, rx_byte_i} > 9'(MaxPayload)) begin
            phase_d = PH_HEAD_L;
          end else begin
            len_d   = LW'(rx_byte_i);
            sum_d   = sum_add;
            cnt_d   = '0;
            phase_d = (rx_byte_i == 8'd0) ? PH_SUM : PH_DATA;
          end
        end
      end
      PH_DATA: begin
        if (in_fire) begin
          sum_d = sum_add;
          if (data_last) begin
            cnt_d   = '0;
            phase_d = PH_SUM;
          end else begin
            cnt_d = cnt_q + AW'(1);
          end
        end
      end
      PH_SUM: begin
        if (in_fire) begin
          idx_d = '0;
          if (rx_byte_i == sum_q && len_q != '0) begin
            phase_d = PH_PLAY;
          end else begin
            phase_d = PH_HEAD_L;
          end
        end
      end
      PH_PLAY: begin
        if (out_free) begin
          if (play_last) begin
            phase_d = PH_HEAD_L;
          end else begin
            idx_d = idx_q + AW'(1);
          end
        end
      end
      default: begin
        phase_d = PH_HEAD_L;
      end
    endcase
  end

  // outputs and memory control
  always_comb begin
    load_out   = 1'b0;
    status_d   = ST_PENDING;
    kind_out_d = 1'b0;
    id_out_d   = 8'd0;
    len_out_d  = 6'd0;
    idx_out_d  = 5'd0;
    byte_out_d = 8'd0;
    last_out_d = 1'b1;
    mem_we     = 1'b0;
    mem_wa     = cnt_q;
    mem_re     = 1'b0;
    mem_ra     = '0;
    unique case (phase_q)
      PH_HEAD_L, PH_ID: begin
        load_out = in_fire;
      end
      PH_HEAD_H: begin
        load_out = in_fire;
        if (rx_byte_i != HEAD_UPLOAD && rx_byte_i != HEAD_ACK) begin
          status_d = ST_ERROR;
        end
      end
      PH_LEN: begin
        load_out = in_fire;
        if ({1'b0, rx_byte_i} > 9'(MaxPayload)) begin
          status_d = ST_ERROR;
        end
      end
      PH_DATA: begin
        load_out = in_fire;
        mem_we   = in_fire;
      end
      PH_SUM: begin
        if (rx_byte_i != sum_q) begin
          load_out = in_fire;
          status_d = ST_ERROR;
        end else if (len_q == '0) begin
          load_out   = in_fire;
          status_d   = ST_GOOD;
          kind_out_d = kind_q;
          id_out_d   = id_q;
        end else begin
          mem_re = in_fire;
        end
      end
      PH_PLAY: begin
        load_out   = out_free;
        status_d   = ST_GOOD;
        kind_out_d = kind_q;
        id_out_d   = id_q;
        len_out_d  = 6'(len_q);
        idx_out_d  = 5'(idx_q);
        byte_out_d = rdata_q;
        last_out_d = play_last;
        mem_re     = out_free && !play_last;
        mem_ra     = idx_q + AW'(1);
      end
      default: begin
        load_out = in_fire;
        status_d = ST_ERROR;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_HEAD_L;
      kind_q      <= 1'b0;
      id_q        <= 8'd0;
      len_q       <= '0;
      cnt_q       <= '0;
      sum_q       <= 8'd0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q <= phase_d;
      kind_q  <= kind_d;
      id_q    <= id_d;
      len_q   <= len_d;
      cnt_q   <= cnt_d;
      sum_q   <= sum_d;
      idx_q   <= idx_d;
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      status_q   <= status_d;
      kind_out_q <= kind_out_d;
      id_out_q   <= id_out_d;
      len_out_q  <= len_out_d;
      idx_out_q  <= idx_out_d;
      byte_out_q <= byte_out_d;
      last_out_q <= last_out_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_wa] <= rx_byte_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_re) begin
      rdata_q <= mem_q[mem_ra];
    end
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = status_q;
  assign frame_kind_o   = kind_out_q;
  assign frame_id_o     = id_out_q;
  assign payload_len_o  = len_out_q;
  assign byte_index_o   = idx_out_q;
  assign payload_byte_o = byte_out_q;
  assign last_o         = last_out_q;

  a_single_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && status_q != ST_GOOD) |-> last_out_q)
    else $error("pending or error word without last");

  a_play_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_PLAY) |-> (len_q != '0 && CW'(idx_q) < CW'(len_q)))
    else $error("replay index outside frame length");

  a_play_continues: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_ready_i && status_q == ST_GOOD && !last_out_q)
      |=> (out_valid_q && status_q == ST_GOOD))
    else $error("payload run broken");

endmodule
